[rtl/bth_pkg.sv]
// Shared types and constants for the BER TLV header parser.
package bth_pkg;

    localparam int unsigned MAX_TAG_BYTES = 8;

    localparam logic [4:0]  LOW_TAG_ESCAPE = 5'h1f;
    localparam logic [2:0]  TAG_TOP_CLEAR  = 3'b000;

    typedef enum logic [1:0] {
        PH_IDENT = 2'd0,
        PH_TAG   = 2'd1,
        PH_LEN1  = 2'd2,
        PH_LENN  = 2'd3
    } phase_t;

endpackage

[rtl/bth_in_if.sv]
// Input channel: one raw header byte per word.
interface bth_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_header;

    modport source (output valid, output data_byte, output start_of_header, input ready);
    modport sink   (input valid, input data_byte, input start_of_header, output ready);
endinterface

[rtl/bth_out_if.sv]
// Output channel: one decoded header per word.
interface bth_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  tag_class;
    logic        constructed;
    logic [31:0] tag_number;
    logic [31:0] content_length;
    logic [7:0]  header_bytes;
    logic        header_error;

    modport source (
        output valid, output tag_class, output constructed, output tag_number,
        output content_length, output header_bytes, output header_error,
        input ready
    );
    modport sink (
        input valid, input tag_class, input constructed, input tag_number,
        input content_length, input header_bytes, input header_error,
        output ready
    );
endinterface

[rtl/ber_tlv_header_parser_top.sv]
// BER TLV header parser top level: byte-wise header decode with registered result.
//
//  channel  dir  word contents
//  header   in   data_byte[7:0], start_of_header
//  result   out  tag_class, constructed, tag_number, content_length,
//                header_bytes, header_error
//
// One byte is taken every cycle while header.ready is high; the parse state updates at the accepting edge.
// A result appears in the output register the cycle after the byte that ends
// the header. header.ready is low only while a result waits and result.ready
// is low. Reset is asynchronous, active low, and returns to identifier wait.
module ber_tlv_header_parser_top #(
    parameter int unsigned MAX_TAG_BYTES = bth_pkg::MAX_TAG_BYTES
) (
    input  logic          clk,
    input  logic          rst_n,
    bth_in_if.sink        header,
    bth_out_if.source     result
);

    bth_pkg::phase_t phase_reg, phase_next;
    logic [1:0]  class_reg, class_next;
    logic        cons_reg, cons_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] len_reg, len_next;
    logic [6:0]  left_reg, left_next;
    logic [7:0]  count_reg, count_next;
    logic [3:0]  seen_reg, seen_next;

    logic        emit;
    logic        emit_err;
    logic        in_acc;
    bth_pkg::phase_t cur_phase;
    logic [7:0]  b;

    logic        ovalid_reg;
    logic [1:0]  oclass_reg;
    logic        ocons_reg;
    logic [31:0] otag_reg;
    logic [31:0] olen_reg;
    logic [7:0]  obytes_reg;
    logic        oerr_reg;

    assign header.ready = !ovalid_reg || result.ready;
    assign in_acc       = header.valid && header.ready;
    assign b            = header.data_byte;
    assign cur_phase    = header.start_of_header ? bth_pkg::PH_IDENT : phase_reg;

    // next-state logic
    always_comb
    begin
        phase_next = cur_phase;
        class_next = class_reg;
        cons_next  = cons_reg;
        tag_next   = tag_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        count_next = count_reg + 8'd1;
        seen_next  = seen_reg;
        emit       = 1'b0;
        emit_err   = 1'b0;
        case (cur_phase)
            bth_pkg::PH_IDENT:
            begin
                class_next = b[7:6];
                cons_next  = b[5];
                count_next = 8'd1;
                seen_next  = 4'd0;
                len_next   = 32'd0;
                left_next  = 7'd0;
                if (b[4:0] != bth_pkg::LOW_TAG_ESCAPE)
                begin
                    tag_next   = {27'd0, b[4:0]};
                    phase_next = bth_pkg::PH_LEN1;
                end
                else
                begin
                    tag_next   = 32'd0;
                    phase_next = bth_pkg::PH_TAG;
                end
            end
            bth_pkg::PH_TAG:
            begin
                tag_next  = {tag_reg[24:0], b[6:0]};
                seen_next = seen_reg + 4'd1;
                if (b[7] && tag_next[27:25] == bth_pkg::TAG_TOP_CLEAR
                    && seen_next < 4'(MAX_TAG_BYTES))
                begin
                    phase_next = bth_pkg::PH_TAG;
                end
                else if (b[7])
                begin
                    emit       = 1'b1;
                    emit_err   = 1'b1;
                    phase_next = bth_pkg::PH_IDENT;
                end
                else
                begin
                    phase_next = bth_pkg::PH_LEN1;
                end
            end
            bth_pkg::PH_LEN1:
            begin
                if (!b[7])
                begin
                    len_next   = {24'd0, b};
                    emit       = 1'b1;
                    phase_next = bth_pkg::PH_IDENT;
                end
                else
                begin
                    len_next  = 32'd0;
                    left_next = b[6:0];
                    if (b[6:0] == 7'd0)
                    begin
                        emit       = 1'b1;
                        phase_next = bth_pkg::PH_IDENT;
                    end
                    else
                    begin
                        phase_next = bth_pkg::PH_LENN;
                    end
                end
            end
            default:
            begin
                len_next  = {len_reg[23:0], b};
                left_next = left_reg - 7'd1;
                if (left_next == 7'd0)
                begin
                    emit       = 1'b1;
                    phase_next = bth_pkg::PH_IDENT;
                end
                else
                begin
                    phase_next = bth_pkg::PH_LENN;
                end
            end
        endcase
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= bth_pkg::PH_IDENT;
            class_reg <= 2'd0;
            cons_reg  <= 1'b0;
            tag_reg   <= 32'd0;
            len_reg   <= 32'd0;
            left_reg  <= 7'd0;
            count_reg <= 8'd0;
            seen_reg  <= 4'd0;
        end
        else if (in_acc)
        begin
            phase_reg <= phase_next;
            class_reg <= class_next;
            cons_reg  <= cons_next;
            tag_reg   <= tag_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            count_reg <= count_next;
            seen_reg  <= seen_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (in_acc && emit)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && emit)
        begin
            oclass_reg <= class_next;
            ocons_reg  <= cons_next;
            otag_reg   <= tag_next;
            olen_reg   <= emit_err ? 32'd0 : len_next;
            obytes_reg <= emit_err ? 8'd0 : count_next;
            oerr_reg   <= emit_err;
        end
    end

    // output drive
    always_comb
    begin
        result.valid          = ovalid_reg;
        result.tag_class      = oclass_reg;
        result.constructed    = ocons_reg;
        result.tag_number     = otag_reg;
        result.content_length = olen_reg;
        result.header_bytes   = obytes_reg;
        result.header_error   = oerr_reg;
    end

endmodule

[rtl/bth_checker.sv]
// Port-level checks for the BER TLV header parser, bound to the top level.
module bth_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        start_of_header,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] content_length,
    input logic [7:0]  header_bytes,
    input logic        header_error
);

    // a waiting result stays until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a rejected header carries no length and no byte count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && header_error |-> content_length == 32'd0 && header_bytes == 8'd0)
        else $error("error word with length or count");

    // a good header is at least identifier plus one length byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !header_error |-> header_bytes >= 8'd2)
        else $error("header too short");

    // an identifier byte never yields a word
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && start_of_header && (!out_valid || out_ready) |=> !out_valid)
        else $error("word from identifier byte");

    // a taken word is not repeated without new input
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !(in_valid && in_ready) |=> !out_valid)
        else $error("word repeated");

endmodule

bind ber_tlv_header_parser_top bth_checker u_bth_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (header.valid),
    .in_ready        (header.ready),
    .start_of_header (header.start_of_header),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .content_length  (result.content_length),
    .header_bytes    (result.header_bytes),
    .header_error    (result.header_error)
);

[verif/ber_tlv_header_parser_top_tb.sv]
// Self-checking testbench for ber_tlv_header_parser_top: directed and random BER headers.
module ber_tlv_header_parser_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_BYTES  = 1600;
    localparam int unsigned DRAIN_EVERY   = 400;
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam logic [7:0]  LONG_FORM     = 8'h80;

    typedef struct packed {
        logic [7:0] data;
        logic       sof;
        logic       drain;
    } hdr_byte_t;

    typedef struct packed {
        logic [1:0]  tag_class;
        logic        constructed;
        logic [31:0] tag_number;
        logic [31:0] content_length;
        logic [7:0]  header_bytes;
        logic        header_error;
    } hdr_word_t;

    logic clk = 1'b0;
    logic rst_n;

    bth_in_if  header_if();
    bth_out_if result_if();

    ber_tlv_header_parser_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .header (header_if),
        .result (result_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    hdr_byte_t   byte_queue[$];
    hdr_word_t   headers_due[$];
    logic [7:0]  hdr_bytes[$];
    int unsigned bytes_queued = 0;
    int unsigned mismatches   = 0;
    int unsigned idle_cycles  = 0;
    bit          resync       = 1'b0;
    bit          drain_next   = 1'b0;

    bit          byte_busy    = 1'b0;
    bit          byte_taken   = 1'b0;
    int unsigned byte_gap     = 0;
    bit          word_taken   = 1'b0;
    bit          stall_drawn  = 1'b0;
    int unsigned word_stall   = 0;
    bit          no_idle      = 1'b0;

    // parser state mirror
    bth_pkg::phase_t p_phase = bth_pkg::PH_IDENT;
    logic [1:0]  p_class    = '0;
    logic        p_cons     = 1'b0;
    logic [31:0] p_tag      = '0;
    logic [31:0] p_len      = '0;
    logic [6:0]  p_len_left = '0;
    logic [7:0]  p_count    = '0;
    logic [3:0]  p_tag_seen = '0;

    function automatic hdr_word_t close_header(input bit err);
        hdr_word_t w;
        w.tag_class      = p_class;
        w.constructed    = p_cons;
        w.tag_number     = p_tag;
        w.content_length = err ? 32'd0 : p_len;
        w.header_bytes   = err ? 8'd0 : p_count;
        w.header_error   = err;
        p_phase          = bth_pkg::PH_IDENT;
        return w;
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, input logic sof,
                                       output hdr_word_t w);
        w = '0;
        if (sof)
            p_phase = bth_pkg::PH_IDENT;
        case (p_phase)
            bth_pkg::PH_IDENT:
            begin
                p_class    = b[7:6];
                p_cons     = b[5];
                p_count    = 8'd1;
                p_tag_seen = '0;
                p_len      = '0;
                p_len_left = '0;
                if (b[4:0] != bth_pkg::LOW_TAG_ESCAPE)
                begin
                    p_tag   = {27'd0, b[4:0]};
                    p_phase = bth_pkg::PH_LEN1;
                end
                else
                begin
                    p_tag   = '0;
                    p_phase = bth_pkg::PH_TAG;
                end
                return 1'b0;
            end
            bth_pkg::PH_TAG:
            begin
                p_tag      = {p_tag[24:0], b[6:0]};
                p_count    = p_count + 8'd1;
                p_tag_seen = p_tag_seen + 4'd1;
                if (b[7] && p_tag[27:25] == bth_pkg::TAG_TOP_CLEAR
                    && p_tag_seen < 4'(bth_pkg::MAX_TAG_BYTES))
                    return 1'b0;
                if (b[7])
                begin
                    w = close_header(1'b1);
                    return 1'b1;
                end
                p_phase = bth_pkg::PH_LEN1;
                return 1'b0;
            end
            bth_pkg::PH_LEN1:
            begin
                p_count = p_count + 8'd1;
                if (!b[7])
                begin
                    p_len = {24'd0, b};
                    w = close_header(1'b0);
                    return 1'b1;
                end
                p_len      = '0;
                p_len_left = b[6:0];
                if (p_len_left == '0)
                begin
                    w = close_header(1'b0);
                    return 1'b1;
                end
                p_phase = bth_pkg::PH_LENN;
                return 1'b0;
            end
            default:
            begin
                p_len      = {p_len[23:0], b};
                p_count    = p_count + 8'd1;
                p_len_left = p_len_left - 7'd1;
                if (p_len_left == '0)
                begin
                    w = close_header(1'b0);
                    return 1'b1;
                end
                return 1'b0;
            end
        endcase
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endtask

    task automatic check_word(input hdr_word_t got);
        hdr_word_t want;
        want = headers_due.pop_front();
        compare_field("tag_class",      32'(want.tag_class),      32'(got.tag_class));
        compare_field("constructed",    32'(want.constructed),    32'(got.constructed));
        compare_field("tag_number",     want.tag_number,          got.tag_number);
        compare_field("content_length", want.content_length,      got.content_length);
        compare_field("header_bytes",   32'(want.header_bytes),   32'(got.header_bytes));
        compare_field("header_error",   32'(want.header_error),   32'(got.header_error));
    endtask

    task automatic push_byte(input logic [7:0] b, input logic sof);
        hdr_byte_t e;
        e.data     = b;
        e.sof      = sof;
        e.drain    = drain_next;
        drain_next = 1'b0;
        byte_queue.push_back(e);
        bytes_queued++;
    endtask

    // kind: 0 low tag, 1 short high tag, 2 long high tag, 3 rejected tag
    task automatic build_header(input int unsigned kind);
        logic [7:0]  b;
        int unsigned groups;
        int unsigned r;
        int unsigned i;
        hdr_bytes.delete();
        b = 8'($urandom_range(0, 255));
        if (kind == 0)
            b[4:0] = 5'($urandom_range(0, 30));
        else
            b[4:0] = bth_pkg::LOW_TAG_ESCAPE;
        hdr_bytes.push_back(b);
        if (kind != 0)
        begin
            if (kind == 1)
                groups = $urandom_range(1, 4);
            else if (kind == 2)
                groups = $urandom_range(5, bth_pkg::MAX_TAG_BYTES);
            else
                groups = bth_pkg::MAX_TAG_BYTES;
            for (i = 0; i < groups; i++)
            begin
                b = 8'($urandom_range(0, 255));
                if (kind != 1 && $urandom_range(0, 4) != 0)
                    b[6:4] = 3'b000;
                b[7] = (kind == 3) || (i + 1 < groups);
                hdr_bytes.push_back(b);
            end
        end
        if (kind == 3)
            return;
        r = $urandom_range(0, 99);
        if (r < 45)
            hdr_bytes.push_back(8'($urandom_range(0, 127)));
        else if (r < 55)
            hdr_bytes.push_back(LONG_FORM);
        else
        begin
            if (r < 95)
                groups = $urandom_range(1, 4);
            else if (r < 99)
                groups = $urandom_range(5, 8);
            else
                groups = $urandom_range(9, 127);
            hdr_bytes.push_back(LONG_FORM | groups[7:0]);
            repeat (groups)
                hdr_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic push_header(input int unsigned count);
        int unsigned i;
        for (i = 0; i < count; i++)
            push_byte(hdr_bytes[i], (i == 0) && (resync || $urandom_range(0, 1) == 1));
        resync = 1'b0;
    endtask

    // driver and receiver
    always @(negedge clk)
    begin
        hdr_byte_t cur;
        if (rst_n)
        begin
            if (byte_taken)
            begin
                byte_taken = 1'b0;
                byte_busy  = 1'b0;
                byte_gap   = no_idle ? 0 : $urandom_range(0, 3);
                if ($urandom_range(0, 99) == 0)
                    no_idle = !no_idle;
            end
            if (!byte_busy)
            begin
                if (byte_gap != 0)
                begin
                    byte_gap--;
                    header_if.valid <= 1'b0;
                end
                else if (byte_queue.size() != 0 &&
                         !(byte_queue[0].drain && headers_due.size() != 0))
                begin
                    cur = byte_queue.pop_front();
                    header_if.valid           <= 1'b1;
                    header_if.data_byte       <= cur.data;
                    header_if.start_of_header <= cur.sof;
                    byte_busy = 1'b1;
                end
                else
                    header_if.valid <= 1'b0;
            end

            if (word_taken)
            begin
                word_taken  = 1'b0;
                stall_drawn = 1'b0;
                word_stall  = 0;
            end
            if (result_if.valid && !stall_drawn)
            begin
                stall_drawn = 1'b1;
                word_stall  = no_idle ? 0 : $urandom_range(0, 3);
            end
            if (word_stall != 0)
            begin
                word_stall--;
                result_if.ready <= 1'b0;
            end
            else
                result_if.ready <= 1'b1;
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        hdr_word_t got;
        hdr_word_t predicted;
        bit        moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (result_if.valid && result_if.ready)
            begin
                moved              = 1'b1;
                word_taken         = 1'b1;
                got.tag_class      = result_if.tag_class;
                got.constructed    = result_if.constructed;
                got.tag_number     = result_if.tag_number;
                got.content_length = result_if.content_length;
                got.header_bytes   = result_if.header_bytes;
                got.header_error   = result_if.header_error;
                if (headers_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected word, expected none, actual %p", $time, got);
                end
                else
                    check_word(got);
            end
            if (header_if.valid && header_if.ready)
            begin
                moved      = 1'b1;
                byte_taken = 1'b1;
                if (decode_byte(header_if.data_byte, header_if.start_of_header, predicted))
                    headers_due.push_back(predicted);
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("ber_tlv_header_parser_top regression: fail");
        $finish;
    end

    initial
    begin
        int unsigned r;
        int unsigned next_drain;
        rst_n                     = 1'b0;
        header_if.valid           = 1'b0;
        header_if.data_byte       = '0;
        header_if.start_of_header = 1'b0;
        result_if.ready           = 1'b0;

        // short form, zero bytes
        push_byte(8'h02, 1'b1); push_byte(8'h05, 1'b0);
        push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
        // high tag, indefinite length
        push_byte(8'hff, 1'b0); push_byte(8'h81, 1'b0);
        push_byte(8'h7f, 1'b0); push_byte(8'h80, 1'b0);
        // tag rejected on top bits
        push_byte(8'h1f, 1'b0); push_byte(8'hff, 1'b0); push_byte(8'hff, 1'b0);
        push_byte(8'hff, 1'b0); push_byte(8'hff, 1'b0);
        // restart mid tag
        push_byte(8'hbf, 1'b0); push_byte(8'h81, 1'b0);
        push_byte(8'h30, 1'b1); push_byte(8'h7f, 1'b0);
        // five length bytes
        push_byte(8'h44, 1'b0); push_byte(8'h85, 1'b0); push_byte(8'haa, 1'b0);
        push_byte(8'h11, 1'b0); push_byte(8'h22, 1'b0); push_byte(8'h33, 1'b0);
        push_byte(8'h44, 1'b0);

        next_drain = bytes_queued;
        while (bytes_queued < RANDOM_BYTES + 24)
        begin
            if (bytes_queued >= next_drain)
            begin
                drain_next = 1'b1;
                next_drain += DRAIN_EVERY;
            end
            r = $urandom_range(0, 99);
            if (r < 65)
            begin
                build_header(r < 35 ? 0 : (r < 55 ? 1 : 2));
                push_header(hdr_bytes.size());
            end
            else if (r < 75)
            begin
                build_header(3);
                push_header(hdr_bytes.size());
                resync = 1'b1;
            end
            else if (r < 87)
            begin
                build_header($urandom_range(0, 2));
                push_header($urandom_range(1, hdr_bytes.size() - 1));
                resync = 1'b1;
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                resync = 1'b1;
            end
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (byte_queue.size() != 0 || byte_busy || headers_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && headers_due.size() == 0)
            $display("ber_tlv_header_parser_top regression: pass");
        else
            $display("ber_tlv_header_parser_top regression: fail");
        $finish;
    end

endmodule
